/* rtl/uart_baud_divisor_calc_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the UART baud divisor calculator.
// ---------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_MACROS_SVH

// Implication in the same cycle, sampled on clk, off during reset.
`define UBDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, sampled on clk, off during reset.
`define UBDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ubdc_pkg.sv */
// ---------------------------------------------------------------------------
// ubdc_pkg
// Shared types and constants of the UART baud divisor calculator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ubdc_pkg;

    localparam int DEFAULT_DIVISOR_BITS = 16;

    localparam int BAUD_W  = 24;
    localparam int CLK_W   = 30;
    localparam int TOL_W   = 12;
    localparam int QUOT_W  = 31;
    localparam int COUNT_W = 31;
    localparam int PROD_W  = 26;
    localparam int NUM1_W  = 34;
    localparam int DEN1_W  = 33;
    localparam int NUM2_W  = 31;

    localparam logic [CLK_W-1:0]  CLOCK_RESET   = 30'd26000000;
    localparam logic [CLK_W-1:0]  SPECIAL_CLOCK = 30'd12000000;
    localparam logic [BAUD_W-1:0] LOW_SPEED_LIMIT = 24'd115200;

    // floor(x / 100) == (x * TOL_RECIP) >> TOL_SHIFT for x below 2^19.
    localparam int TOL_SHIFT = 26;
    localparam logic [19:0] TOL_RECIP = 20'd671089;

    localparam logic [1:0] PATH_X16     = 2'd0;
    localparam logic [1:0] PATH_SPECIAL = 2'd1;
    localparam logic [1:0] PATH_HIGH    = 2'd2;

    localparam logic [1:0] MODE_X16     = 2'd0;
    localparam logic [1:0] MODE_SAMPLED = 2'd3;

    typedef struct packed {
        logic [BAUD_W-1:0]  baud;
        logic [CLK_W-1:0]   ref_hz;
        logic [1:0]         path;
        logic [TOL_W-1:0]   tol;
        logic [QUOT_W-1:0]  quot;
        logic [COUNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic [NUM1_W-1:0] num;
        logic [DEN1_W-1:0] den;
        job_t              job;
    } item_t;

    typedef struct packed {
        logic [1:0]  speed_mode;
        logic [15:0] divisor;
        logic [7:0]  sample_count_word;
        logic [7:0]  sample_point_word;
        logic        rate_out_of_tolerance;
    } result_t;

endpackage

/* rtl/uart_baud_divisor_calc.sv */
// ---------------------------------------------------------------------------
// uart_baud_divisor_calc
// Computes UART speed mode, divisor and sample words from a baud rate.
// ---------------------------------------------------------------------------
// Usage: write the reference clock in hertz through wr_en/wr_data while no
// request is in flight; it resets to 26 MHz. Each request is a transfer of
// baud_rate on the input queue (push while full is low). Each request gives
// exactly one result transfer on the output queue: the oldest result sits on
// the result ports while empty is low and leaves on a cycle with pop high.
// A request enters a short queue in the cycle it is taken, then runs through
// four pipelined restoring dividers (divisor, sample count, and the two
// divisions of the real rate) at one quotient bit per stage, plus one
// multiply stage between the first two, and the result then waits in the
// result queue. Throughput is one request per cycle while the receiver
// keeps popping, set by the per-bit divider stages.
// If the receiver stops popping, the back pipeline freezes once its last
// stage holds a result the output queue cannot take; the input queue then
// fills and full rises. Reset empties both queues and the pipeline and
// restores the clock register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_baud_divisor_calc #(
    parameter int DIVISOR_BITS = ubdc_pkg::DEFAULT_DIVISOR_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [ubdc_pkg::CLK_W-1:0]  wr_data,
    input  logic                        push,
    output logic                        full,
    input  logic [ubdc_pkg::BAUD_W-1:0] baud_rate,
    input  logic                        pop,
    output logic                        empty,
    output logic [1:0]                  speed_mode,
    output logic [15:0]                 divisor,
    output logic [7:0]                  sample_count_word,
    output logic [7:0]                  sample_point_word,
    output logic                        rate_out_of_tolerance
);
    import ubdc_pkg::*;

    item_t   front_item;
    item_t   q_item;
    logic    q_empty;
    logic    q_pop;
    logic    res_full;
    logic    res_push;
    result_t back_res;
    result_t head_res;

    // Front: clock register and request classification.
    ubdc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_data(wr_data),
        .baud_rate(baud_rate), .item(front_item)
    );

    // Queue that decouples the front from the divider pipeline.
    ubdc_fifo #(.WIDTH($bits(item_t)), .DEPTH(4)) u_job_q (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .wdata(front_item),
        .pop(q_pop), .empty(q_empty), .rdata(q_item)
    );

    // Back: the divider pipeline.
    ubdc_back #(.DIVISOR_BITS(DIVISOR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
        .res_full(res_full), .res_push(res_push), .res(back_res)
    );

    // Result queue, so the pipeline keeps moving while a result waits.
    ubdc_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
        .clk(clk), .rst_n(rst_n),
        .push(res_push), .full(res_full), .wdata(back_res),
        .pop(pop), .empty(empty), .rdata(head_res)
    );

    assign speed_mode            = head_res.speed_mode;
    assign divisor               = head_res.divisor;
    assign sample_count_word     = head_res.sample_count_word;
    assign sample_point_word     = head_res.sample_point_word;
    assign rate_out_of_tolerance = head_res.rate_out_of_tolerance;
endmodule

/* rtl/ubdc_fifo.sv */
// ---------------------------------------------------------------------------
// ubdc_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubdc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW:0] wr_ptr_reg;
    logic [AW:0] rd_ptr_reg;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign rdata = mem[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg[AW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end
endmodule

/* rtl/ubdc_div.sv */
// ---------------------------------------------------------------------------
// ubdc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubdc_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [TAG_W-1:0] out_tag
);
    logic             val_reg [1:NUM_W];
    logic [NUM_W-1:0] num_reg [1:NUM_W];
    logic [NUM_W-1:0] quo_reg [1:NUM_W];
    logic [DEN_W-1:0] rem_reg [1:NUM_W];
    logic [DEN_W-1:0] den_reg [1:NUM_W];
    logic [TAG_W-1:0] tag_reg [1:NUM_W];

    for (genvar s = 1; s <= NUM_W; s++)
    begin : g_stage
        logic             v_prev;
        logic [NUM_W-1:0] n_prev;
        logic [NUM_W-1:0] q_prev;
        logic [DEN_W-1:0] r_prev;
        logic [DEN_W-1:0] d_prev;
        logic [TAG_W-1:0] t_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (s == 1)
        begin : g_first
            assign v_prev = in_valid;
            assign n_prev = in_num;
            assign q_prev = '0;
            assign r_prev = '0;
            assign d_prev = in_den;
            assign t_prev = in_tag;
        end
        else
        begin : g_next
            assign v_prev = val_reg[s-1];
            assign n_prev = num_reg[s-1];
            assign q_prev = quo_reg[s-1];
            assign r_prev = rem_reg[s-1];
            assign d_prev = den_reg[s-1];
            assign t_prev = tag_reg[s-1];
        end

        assign trial = {r_prev, n_prev[NUM_W-1]};
        assign diff  = trial - {1'b0, d_prev};
        assign ge    = (trial >= {1'b0, d_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                val_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= n_prev << 1;
                quo_reg[s] <= {q_prev[NUM_W-2:0], ge};
                rem_reg[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                den_reg[s] <= d_prev;
                tag_reg[s] <= t_prev;
            end
        end
    end

    // A zero divisor yields a zero quotient.
    assign out_valid = val_reg[NUM_W];
    assign out_quo   = (den_reg[NUM_W] == '0) ? '0 : quo_reg[NUM_W];
    assign out_tag   = tag_reg[NUM_W];
endmodule

/* rtl/ubdc_front.sv */
// ---------------------------------------------------------------------------
// ubdc_front
// Holds the clock register, classifies each request and forms dividend,
// divisor and tolerance for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ubdc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ubdc_pkg::CLK_W-1:0]    wr_data,
    input  logic [ubdc_pkg::BAUD_W-1:0]   baud_rate,
    output ubdc_pkg::item_t               item
);
    import ubdc_pkg::*;

    logic [CLK_W-1:0]  clock_rate_reg;
    logic [BAUD_W-1:0] baud;
    logic              low;
    logic              special;
    logic [DEN1_W-1:0] den;
    logic [NUM1_W-1:0] bias;
    logic [18:0]       tol_x;
    logic [38:0]       tol_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg <= CLOCK_RESET;
        end
        else if (wr_en)
        begin
            clock_rate_reg <= wr_data;
        end
    end

    always_comb
    begin
        baud    = (baud_rate == '0) ? BAUD_W'(1) : baud_rate;
        low     = (baud <= LOW_SPEED_LIMIT);
        special = low && (clock_rate_reg == SPECIAL_CLOCK);
        if (low && !special)
        begin
            den = {5'b0, baud, 4'b0};
        end
        else
        begin
            den = {1'b0, baud, 8'b0};
        end
        // Round up on the fast path, to nearest elsewhere.
        if (!low)
        begin
            bias = {1'b0, den} - 1'b1;
        end
        else
        begin
            bias = {2'b0, den[DEN1_W-1:1]};
        end
        tol_x    = {2'b0, baud[16:0]} * 19'd3;
        tol_prod = {20'b0, tol_x} * {19'b0, TOL_RECIP};

        item.num          = {4'b0, clock_rate_reg} + bias;
        item.den          = den;
        item.job.baud     = baud;
        item.job.ref_hz   = clock_rate_reg;
        item.job.path     = special ? PATH_SPECIAL : (low ? PATH_X16 : PATH_HIGH);
        item.job.tol      = tol_prod[TOL_SHIFT+TOL_W-1:TOL_SHIFT];
        item.job.quot     = '0;
        item.job.count    = '0;
    end
endmodule

/* rtl/ubdc_back.sv */
// ---------------------------------------------------------------------------
// ubdc_back
// Divider pipeline: divisor, sample count, real rate and tolerance check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_baud_divisor_calc_macros.svh"

module ubdc_back #(
    parameter int DIVISOR_BITS = ubdc_pkg::DEFAULT_DIVISOR_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ubdc_pkg::item_t   q_item,
    output logic              q_pop,
    input  logic              res_full,
    output logic              res_push,
    output ubdc_pkg::result_t res
);
    import ubdc_pkg::*;

    localparam int JOB_W = $bits(job_t);

    logic              en;
    logic              d1_valid;
    logic [NUM1_W-1:0] d1_quo;
    logic [JOB_W-1:0]  d1_tag;
    job_t              d1_job;
    logic [QUOT_W-1:0] qfix;
    logic [54:0]       prod;

    logic              b_valid_reg;
    job_t              b_job_reg;
    job_t              b_job_next;
    logic [PROD_W-1:0] b_prod_reg;

    logic              d2_valid;
    logic [NUM2_W-1:0] d2_quo;
    logic [JOB_W-1:0]  d2_tag;
    job_t              d2_job;
    job_t              d3_in_job;

    logic              d3_valid;
    logic [CLK_W-1:0]  d3_quo;
    logic [JOB_W-1:0]  d3_tag;
    job_t              d3_job;

    logic              d4_valid;
    logic [CLK_W-1:0]  d4_quo;
    logic [JOB_W-1:0]  d4_tag;
    job_t              j;

    logic [31:0]       count32;
    logic [31:0]       cw;
    logic [31:0]       pw;
    logic [BAUD_W:0]   hi_lim;
    logic [BAUD_W:0]   lo_lim;
    logic              miss;

    assign en    = !(d4_valid && res_full);
    assign q_pop = en && !q_empty;

    ubdc_div #(.NUM_W(NUM1_W), .DEN_W(DEN1_W), .TAG_W(JOB_W)) u_div_quot (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(q_pop), .in_num(q_item.num), .in_den(q_item.den),
        .in_tag(q_item.job),
        .out_valid(d1_valid), .out_quo(d1_quo), .out_tag(d1_tag)
    );

    always_comb
    begin
        d1_job = job_t'(d1_tag);
        qfix   = d1_quo[QUOT_W-1:0];
        if (d1_job.path == PATH_SPECIAL && qfix == '0)
        begin
            qfix = QUOT_W'(1);
        end
        prod = qfix * d1_job.baud;
        b_job_next      = d1_job;
        b_job_next.quot = qfix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_job_reg  <= b_job_next;
            b_prod_reg <= prod[PROD_W-1:0];
        end
    end

    ubdc_div #(.NUM_W(NUM2_W), .DEN_W(PROD_W), .TAG_W(JOB_W)) u_div_count (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(b_valid_reg),
        .in_num({1'b0, b_job_reg.ref_hz} + {6'b0, b_prod_reg[PROD_W-1:1]}),
        .in_den(b_prod_reg), .in_tag(b_job_reg),
        .out_valid(d2_valid), .out_quo(d2_quo), .out_tag(d2_tag)
    );

    always_comb
    begin
        d2_job          = job_t'(d2_tag);
        d3_in_job       = d2_job;
        d3_in_job.count = d2_quo;
    end

    ubdc_div #(.NUM_W(CLK_W), .DEN_W(COUNT_W), .TAG_W(JOB_W)) u_div_real1 (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d2_valid), .in_num(d2_job.ref_hz), .in_den(d2_quo),
        .in_tag(d3_in_job),
        .out_valid(d3_valid), .out_quo(d3_quo), .out_tag(d3_tag)
    );

    assign d3_job = job_t'(d3_tag);

    ubdc_div #(.NUM_W(CLK_W), .DEN_W(QUOT_W), .TAG_W(JOB_W)) u_div_real2 (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d3_valid), .in_num(d3_quo), .in_den(d3_job.quot),
        .in_tag(d3_tag),
        .out_valid(d4_valid), .out_quo(d4_quo), .out_tag(d4_tag)
    );

    always_comb
    begin
        j = job_t'(d4_tag);
        if (j.path == PATH_X16)
        begin
            count32 = 32'd1;
        end
        else
        begin
            count32 = {1'b0, j.count};
        end
        cw     = count32 - 32'd1;
        pw     = count32 - 32'd2;
        hi_lim = {1'b0, j.baud} + {13'b0, j.tol};
        lo_lim = {1'b0, j.baud} - {13'b0, j.tol};
        miss   = ({1'b0, d4_quo} > {6'b0, hi_lim}) || ({1'b0, d4_quo} < {6'b0, lo_lim});

        res.speed_mode            = (j.path == PATH_X16) ? MODE_X16 : MODE_SAMPLED;
        res.divisor               = 16'({{(QUOT_W-DIVISOR_BITS){1'b0}},
                                         j.quot[DIVISOR_BITS-1:0]});
        res.sample_count_word     = cw[7:0];
        res.sample_point_word     = pw[8:1];
        res.rate_out_of_tolerance = (j.path == PATH_SPECIAL) && miss;
    end

    assign res_push = d4_valid && !res_full;

    `UBDC_ASSERT_NOW(a_x16_words, res_push && res.speed_mode == MODE_X16,
        res.sample_count_word == 8'd0 && res.sample_point_word == 8'hff &&
        !res.rate_out_of_tolerance, "x16 result with wrong sample words or flag")
    `UBDC_ASSERT_NEXT(a_stall_holds, d4_valid && res_full,
        d4_valid && $stable(d4_tag), "stalled result changed in the pipeline")
    `UBDC_ASSERT_NOW(a_special_quot, b_valid_reg && b_job_reg.path == PATH_SPECIAL,
        b_job_reg.quot != '0, "special path divisor below one")
endmodule

/* tb/tb_uart_baud_divisor_calc.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_uart_baud_divisor_calc
// Self-checking bench for the UART baud divisor calculator: baud requests are
// pushed through the input queue, and every popped result is compared field
// by field with a behavioral prediction made when the request was accepted.
// ---------------------------------------------------------------------------

module tb_uart_baud_divisor_calc;

    import ubdc_pkg::*;

    // Expected register settings for one baud request.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] dl;
        logic [7:0]  cnt_word;
        logic [7:0]  pt_word;
        logic        off_tol;
    } uart_setting_t;

    localparam int LATENCY_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 3000000;

    logic              clk;
    logic              rst_n;
    logic              wr_en;
    logic [CLK_W-1:0]  wr_data;
    logic              push;
    logic              full;
    logic [BAUD_W-1:0] baud_rate;
    logic              pop;
    logic              empty;
    logic [1:0]        speed_mode;
    logic [15:0]       divisor;
    logic [7:0]        sample_count_word;
    logic [7:0]        sample_point_word;
    logic              rate_out_of_tolerance;

    // Requests waiting for the driver, and settings waiting for the monitor.
    logic [BAUD_W-1:0] baud_requests[$];
    uart_setting_t     expected_settings[$];

    // The prediction uses the clock value that write_clock last wrote.
    logic [CLK_W-1:0] ref_clock_hz;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    bit  failed;
    longint cycle_count = 0;

    uart_baud_divisor_calc u_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .wr_en                 (wr_en),
        .wr_data               (wr_data),
        .push                  (push),
        .full                  (full),
        .baud_rate             (baud_rate),
        .pop                   (pop),
        .empty                 (empty),
        .speed_mode            (speed_mode),
        .divisor               (divisor),
        .sample_count_word     (sample_count_word),
        .sample_point_word     (sample_point_word),
        .rate_out_of_tolerance (rate_out_of_tolerance)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Rounded and ceiling division that give 0 for a zero denominator.
    function automatic longint unsigned round_div(longint unsigned num,
                                                  longint unsigned den);
        if (den == 0)
            return 0;
        return (num + den / 2) / den;
    endfunction

    function automatic longint unsigned ceil_div(longint unsigned num,
                                                 longint unsigned den);
        if (den == 0)
            return 0;
        return (num + den - 1) / den;
    endfunction

    // Works out the register settings for one baud rate at a given clock.
    function automatic uart_setting_t predict_setting(logic [CLK_W-1:0] clk_hz,
                                                      logic [BAUD_W-1:0] req);
        longint unsigned baud;
        longint unsigned fclk;
        longint unsigned dl;
        longint unsigned cnt;
        longint unsigned tol;
        longint unsigned real_rate;
        logic [31:0]     cw;
        logic [31:0]     pw;
        uart_setting_t   s;
        baud = req;
        fclk = clk_hz;
        cnt = 1;
        real_rate = 0;
        s.off_tol = 1'b0;
        if (baud == 0)
            baud = 1;
        if (baud <= LOW_SPEED_LIMIT && clk_hz == SPECIAL_CLOCK)
        begin
            // The 12 MHz path aims at 256-fold oversampling and checks the error.
            tol = baud * 3 / 100;
            s.mode = MODE_SAMPLED;
            dl = round_div(fclk, 256 * baud);
            if (dl == 0)
                dl = 1;
            cnt = round_div(fclk, dl * baud);
            if (cnt != 0)
                real_rate = fclk / cnt / dl;
            if (real_rate > baud + tol || real_rate < baud - tol)
                s.off_tol = 1'b1;
        end
        else if (baud <= LOW_SPEED_LIMIT)
        begin
            s.mode = MODE_X16;
            dl = round_div(fclk, 16 * baud);
        end
        else
        begin
            s.mode = MODE_SAMPLED;
            dl = ceil_div(fclk, 256 * baud);
            cnt = round_div(fclk, dl * baud);
        end
        cw = 32'(cnt) - 32'd1;
        pw = (32'(cnt) - 32'd2) >> 1;
        s.dl = dl[15:0];
        s.cnt_word = cw[7:0];
        s.pt_word = pw[7:0];
        return s;
    endfunction

    // Driver: offers queued requests on push and predicts each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            baud_rate <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_settings.push_back(predict_setting(ref_clock_hz, baud_rate));
                void'(baud_requests.pop_front());
            end
            // The held item is removed above; decide on the next offer.
            if (push && full)
            begin
                // A request not yet taken stays on the port.
            end
            else if (baud_requests.size() > 0 &&
                     $urandom_range(99, 0) >= send_idle_pct)
            begin
                push <= 1'b1;
                baud_rate <= baud_requests[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: pops results, compares each field with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        uart_setting_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_settings.size() == 0)
                begin
                    $display("%0t: result with none expected: mode %0d dl %0d", $time,
                             speed_mode, divisor);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_settings.pop_front();
                    if (speed_mode !== want.mode)
                    begin
                        $display("%0t: speed_mode expected %0d actual %0d", $time,
                                 want.mode, speed_mode);
                        failed = 1'b1;
                    end
                    if (divisor !== want.dl)
                    begin
                        $display("%0t: divisor expected %0d actual %0d", $time,
                                 want.dl, divisor);
                        failed = 1'b1;
                    end
                    if (sample_count_word !== want.cnt_word)
                    begin
                        $display("%0t: sample_count_word expected %0d actual %0d", $time,
                                 want.cnt_word, sample_count_word);
                        failed = 1'b1;
                    end
                    if (sample_point_word !== want.pt_word)
                    begin
                        $display("%0t: sample_point_word expected %0d actual %0d", $time,
                                 want.pt_word, sample_point_word);
                        failed = 1'b1;
                    end
                    if (rate_out_of_tolerance !== want.off_tol)
                    begin
                        $display("%0t: rate_out_of_tolerance expected %0d actual %0d",
                                 $time, want.off_tol, rate_out_of_tolerance);
                        failed = 1'b1;
                    end
                end
            end
            // During a long hold-off the receiver takes nothing.
            if (recv_hold)
            begin
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Waits until every request has been taken and every result checked.
    task automatic wait_drained();
        while (baud_requests.size() > 0 || push || expected_settings.size() > 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    // Changes the reference clock while the block is idle.
    task automatic write_clock(logic [CLK_W-1:0] hz);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_data <= hz;
        @(posedge clk);
        wr_en <= 1'b0;
        ref_clock_hz = hz;
    endtask

    // Random baud rates weighted toward the low-speed boundary and small rates.
    function automatic logic [BAUD_W-1:0] random_baud();
        case ($urandom_range(5, 0))
            0: return $urandom_range(300, 0);
            1: return $urandom_range(115201, 115199);
            2: return $urandom_range(115200, 1);
            3: return $urandom_range(16000000, 115201);
            4: return $urandom_range(24'hffffff, 0);
            default: return $urandom_range(4000000, 1);
        endcase
    endfunction

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) baud_requests.push_back(random_baud());
        wait_drained();
    endtask

    initial
    begin
        logic [CLK_W-1:0] clocks[7];
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        ref_clock_hz = CLOCK_RESET;
        wr_en = 1'b0;
        wr_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset clock: zero baud, the boundary and extremes.
        baud_requests = '{24'd0, 24'd1, 24'd9600, 24'd115200, 24'd115201,
                          24'd16000000, 24'hffffff, 24'haaaaaa, 24'h555555};
        wait_drained();

        // The 12 MHz path, including rates that miss the tolerance window.
        write_clock(SPECIAL_CLOCK);
        baud_requests = '{24'd0, 24'd1, 24'd110, 24'd9600, 24'd57600,
                          24'd115200, 24'd115201, 24'd3000000, 24'd16000000};
        wait_drained();

        // Zero clock gives zero divisor and count; the largest clock is the other extreme.
        write_clock('0);
        baud_requests = '{24'd1, 24'd115200, 24'd200000};
        wait_drained();
        write_clock({CLK_W{1'b1}});
        baud_requests = '{24'd0, 24'd115200, 24'd115201, 24'hffffff};
        wait_drained();

        clocks = '{CLOCK_RESET, SPECIAL_CLOCK, 30'd1, 30'd1000000000,
                   30'd1843200, 30'd48000000, 30'd0};
        foreach (clocks[i])
        begin
            write_clock(i == 6 ? CLK_W'($urandom) : clocks[i]);
            run_phase(55, 0, 0);
            run_phase(55, 47, 0);
            run_phase(55, 0, 47);
            run_phase(55, 13, 13);
        end

        // Receiver holds off for a long stretch while requests keep coming.
        write_clock(SPECIAL_CLOCK);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b1;
        repeat (150) baud_requests.push_back(random_baud());
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
        wait_drained();

        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ubdc_pkg.sv
rtl/ubdc_fifo.sv
rtl/ubdc_div.sv
rtl/ubdc_front.sv
rtl/ubdc_back.sv
rtl/uart_baud_divisor_calc.sv
tb/tb_uart_baud_divisor_calc.sv
